[rtl/core/igwm_pkg.sv]
// shared types and constants for the interarrival gap window maximum core
`timescale 1ns / 1ps
package igwm_pkg;

  localparam int TS_W = 64;
  localparam int DEFAULT_GAPS_PER_INTERVAL = 64;
  localparam int DEFAULT_INTERVALS_PER_WINDOW = 8;

  typedef logic [TS_W-1:0] ts_t;

  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_FETCH   = 1'b1;

  // write of a closed interval peak into the head of the slot chain
  typedef struct packed {
    logic shift;
    ts_t  peak;
  } slot_write_t;

endpackage

[rtl/core/igwm_in_if.sv]
// input channel: arrival or fetch beats
`timescale 1ns / 1ps
interface igwm_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  igwm_pkg::ts_t     arrival_time;

  modport source (output valid, output action, output arrival_time, input ready);
  modport sink   (input valid, input action, input arrival_time, output ready);
endinterface

[rtl/core/igwm_out_if.sv]
// output channel: one result beat per input beat
`timescale 1ns / 1ps
interface igwm_out_if;
  logic              valid;
  logic              ready;
  igwm_pkg::ts_t     gap;
  logic              gap_valid;
  logic              interval_closed;
  igwm_pkg::ts_t     window_max_gap;
  logic              window_pending;

  modport source (output valid, output gap, output gap_valid, output interval_closed,
                  output window_max_gap, output window_pending, input ready);
  modport sink   (input valid, input gap, input gap_valid, input interval_closed,
                  input window_max_gap, input window_pending, output ready);
endinterface

[rtl/core/igwm_cell.sv]
// one slot cell: holds an interval peak and folds it into the running maximum
`timescale 1ns / 1ps
module igwm_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  igwm_pkg::ts_t peak_in,
  input  igwm_pkg::ts_t max_in,
  output igwm_pkg::ts_t peak_out,
  output igwm_pkg::ts_t max_out
);
  import igwm_pkg::*;

  ts_t peak;
  ts_t run_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak    <= '0;
      run_max <= '0;
    end else begin
      if (shift) begin
        peak <= peak_in;
      end
      run_max <= (peak > max_in) ? peak : max_in;
    end
  end

  assign peak_out = peak;
  assign max_out  = run_max;
endmodule

[rtl/core/igwm_chain.sv]
// row of slot cells; oldest peak drops off the tail, maximum ripples one cell a cycle
`timescale 1ns / 1ps
module igwm_chain #(
  parameter int INTERVALS_PER_WINDOW = igwm_pkg::DEFAULT_INTERVALS_PER_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  igwm_pkg::slot_write_t wr,
  output igwm_pkg::ts_t         window_max
);
  import igwm_pkg::*;

  ts_t peak_q [INTERVALS_PER_WINDOW];
  ts_t max_q  [INTERVALS_PER_WINDOW];

  for (genvar k = 0; k < INTERVALS_PER_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      igwm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (wr.shift),
        .peak_in  (wr.peak),
        .max_in   ('0),
        .peak_out (peak_q[k]),
        .max_out  (max_q[k])
      );
    end else begin : g_body
      igwm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (wr.shift),
        .peak_in  (peak_q[k-1]),
        .max_in   (max_q[k-1]),
        .peak_out (peak_q[k]),
        .max_out  (max_q[k])
      );
    end
  end

  assign window_max = max_q[INTERVALS_PER_WINDOW-1];
endmodule

[rtl/core/interarrival_gap_window_max_core.sv]
// top level: gap measurement, interval tracking and window maximum sequencing
//
//  channel   dir  fields
//  arrivals  in   action, arrival_time
//  results   out  gap, gap_valid, interval_closed, window_max_gap, window_pending
//
// a fetch or an arrival that does not close an interval loads the result register when it is accepted
// an arrival that closes an interval loads it when the scan ends, once the maximum
// has rippled down the row of slot cells
// synchronous reset clears all control state including the slot peaks, but not the result data fields
// arrivals is ready only when no item is in work and the result register is free or draining
`timescale 1ns / 1ps
module interarrival_gap_window_max_core #(
  parameter int GAPS_PER_INTERVAL    = igwm_pkg::DEFAULT_GAPS_PER_INTERVAL,
  parameter int INTERVALS_PER_WINDOW = igwm_pkg::DEFAULT_INTERVALS_PER_WINDOW
) (
  input  logic        clk,
  input  logic        rst,
  igwm_in_if.sink     arrivals,
  igwm_out_if.source  results
);
  import igwm_pkg::*;

  localparam int CNT_W  = (GAPS_PER_INTERVAL > 1) ? $clog2(GAPS_PER_INTERVAL) : 1;
  localparam int SCAN_W = $clog2(INTERVALS_PER_WINDOW + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic              state;
  logic [SCAN_W-1:0] scan_cnt;
  ts_t               last_arrival;
  logic [CNT_W-1:0]  interval_count;
  ts_t               interval_peak;
  ts_t               window_peak;
  logic              pending_flag;

  logic              res_valid;
  ts_t               res_gap;
  logic              res_gap_valid;
  logic              res_closed;
  ts_t               res_window;
  logic              res_pending;

  slot_write_t       wr;
  ts_t               chain_max;

  logic              accept;
  logic              has_prev;
  ts_t               gap_calc;
  ts_t               peak_new;
  logic              closing;
  logic              scan_done;
  logic              res_load;

  assign arrivals.ready = (state == ST_IDLE) && (!res_valid || results.ready);
  assign accept         = arrivals.valid && arrivals.ready;

  assign has_prev = (last_arrival != '0);
  assign gap_calc = arrivals.arrival_time - last_arrival;
  assign peak_new = (gap_calc > interval_peak) ? gap_calc : interval_peak;
  assign closing  = has_prev && (interval_count == CNT_W'(GAPS_PER_INTERVAL - 1));

  assign wr.shift = accept && (arrivals.action == ACT_ARRIVAL) && closing;
  assign wr.peak  = peak_new;

  // result register loads on a beat that needs no scan, or when the scan ends
  assign scan_done = (state == ST_SCAN) && (scan_cnt == SCAN_W'(INTERVALS_PER_WINDOW));
  assign res_load  = (accept && !wr.shift) || scan_done;

  igwm_chain #(
    .INTERVALS_PER_WINDOW (INTERVALS_PER_WINDOW)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .window_max (chain_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scan_cnt       <= '0;
      last_arrival   <= '0;
      interval_count <= '0;
      interval_peak  <= '0;
      window_peak    <= '0;
      pending_flag   <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (arrivals.action == ACT_FETCH) begin
              res_gap       <= '0;
              res_gap_valid <= 1'b0;
              res_closed    <= 1'b0;
              res_window    <= window_peak;
              res_pending   <= pending_flag;
              pending_flag  <= 1'b0;
            end else begin
              last_arrival  <= arrivals.arrival_time;
              res_gap       <= has_prev ? gap_calc : '0;
              res_gap_valid <= has_prev;
              res_closed    <= closing;
              if (closing) begin
                interval_count <= '0;
                interval_peak  <= '0;
                scan_cnt       <= '0;
                state          <= ST_SCAN;
              end else begin
                if (has_prev) begin
                  interval_count <= interval_count + 1'b1;
                  interval_peak  <= peak_new;
                end
                res_window  <= window_peak;
                res_pending <= pending_flag;
              end
            end
          end
        end
        ST_SCAN: begin
          // tail of the row holds the full maximum once it has rippled past every cell
          if (scan_done) begin
            window_peak  <= chain_max;
            pending_flag <= 1'b1;
            res_window   <= chain_max;
            res_pending  <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign results.valid           = res_valid;
  assign results.gap             = res_gap;
  assign results.gap_valid       = res_gap_valid;
  assign results.interval_closed = res_closed;
  assign results.window_max_gap  = res_window;
  assign results.window_pending  = res_pending;
endmodule
